@@ rtl/tot_charge_digitizer_core_macros.svh @@
// Assertion helpers for the digitizer core RTL.
`ifndef TOT_CHARGE_DIGITIZER_CORE_MACROS_SVH
`define TOT_CHARGE_DIGITIZER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcd assertion failed");

// Next-cycle implication, checked outside reset.
`define TCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcd assertion failed");

`endif

@@ rtl/tcd_pkg.sv @@
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared constants and register indexes for the TOT charge digitizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcd_pkg;

    localparam int CHARGE_W  = 24;
    localparam int THRESH_W  = 20;
    localparam int CURRENT_W = 12;
    localparam int CTIME_W   = 12;
    localparam int TRISE_W   = 22;   // charge time in ps
    localparam int PERIOD_W  = 16;
    localparam int OFFSET_W  = 16;
    localparam int TICK_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // quotient bits per divider chain, covers the widest time in ps
    localparam int QUO_W = 35;

    localparam logic [TICK_W-1:0]    TICK_MAX        = 24'hFFFFFF;
    localparam logic [CURRENT_W-1:0] DEFAULT_CURRENT = 12'd60;
    localparam logic [9:0]           PS_PER_NS       = 10'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_THRESHOLD = 3'd0,
        IDX_CURRENT   = 3'd1,
        IDX_CTIME     = 3'd2,
        IDX_PERIOD    = 3'd3,
        IDX_OFFSET    = 3'd4
    } cfg_idx_t;

endpackage

@@ rtl/tot_charge_digitizer_core.sv @@
// ----------------------------------------------------------------------------
// tot_charge_digitizer_core
// Time-over-threshold digitizer: charge in, start/stop/TOT ticks out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries charge_e; output channel
// out_valid/out_ready carries tot_ticks, start_tick, stop_tick and
// below_threshold, one result transaction per input transaction, in order.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data), to
// be written only while no transaction is in flight; no logic enforces it.
// Throughput: one transaction per clock while the receiver takes results.
// The pipeline is two ranks of 35-cell division chains (charge ratio and
// discharge time, then the two tick conversions) plus four register stages.
// When out_valid is up and the receiver stalls, the whole pipeline holds and
// in_ready drops; it resumes without loss as soon as the result is taken.
// Reset loads the register defaults (threshold 3000 e, current 60 e/ns,
// charge time 100 ns, period 6410 ps, offset 0) and empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tot_charge_digitizer_core_macros.svh"

module tot_charge_digitizer_core
    import tcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CHARGE_W-1:0]   charge_e,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TICK_W-1:0]     tot_ticks,
    output logic [TICK_W-1:0]     start_tick,
    output logic [TICK_W-1:0]     stop_tick,
    output logic                  below_threshold
);

    localparam int NSTG = 2 * QUO_W + 4;
    localparam int N1W  = TRISE_W + THRESH_W;       // tr_ps * threshold
    localparam int N2W  = CHARGE_W + 10;            // charge excess * 1000
    localparam int T1W  = TRISE_W + 1;
    localparam int T2W  = QUO_W;

    // configuration
    logic [THRESH_W-1:0]  thresh_reg;
    logic [CURRENT_W-1:0] cur_reg;
    logic [TRISE_W-1:0]   trise_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [OFFSET_W-1:0]  offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= 20'd3000;
            cur_reg    <= DEFAULT_CURRENT;
            trise_reg  <= 22'd100000;
            period_reg <= 16'd6410;
            offset_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                IDX_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                IDX_CURRENT:   cur_reg <= (cfg_data[CURRENT_W-1:0] == '0) ?
                                   DEFAULT_CURRENT : cfg_data[CURRENT_W-1:0];
                IDX_CTIME:     trise_reg <= TRISE_W'(cfg_data[CTIME_W-1:0] *
                                   TRISE_W'(PS_PER_NS));
                IDX_PERIOD:    period_reg <= (cfg_data[PERIOD_W-1:0] == '0) ?
                                   PERIOD_W'(1) : cfg_data[PERIOD_W-1:0];
                IDX_OFFSET:    offset_reg <= cfg_data[OFFSET_W-1:0];
                default:       ;
            endcase
        end
    end

    // pipeline control: everything advances together
    logic en;
    logic valid_reg [NSTG];
    logic below_reg [NSTG];

    assign en       = !valid_reg[NSTG-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // stage 0: not-above-threshold substitution
    logic                below_in;
    logic [CHARGE_W-1:0] q_reg;
    logic [THRESH_W-1:0] qt_reg;

    assign below_in = (charge_e <= CHARGE_W'(thresh_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            below_reg[0] <= below_in;
            for (int i = 1; i < NSTG; i++)
            begin
                below_reg[i] <= below_reg[i-1];
            end
            q_reg  <= below_in ? CHARGE_W'(1) : charge_e;
            qt_reg <= below_in ? THRESH_W'(1) : thresh_reg;
        end
    end

    // stage 1: numerators
    logic [N1W-1:0]      num1_reg;
    logic [N2W-1:0]      num2_reg;
    logic [CHARGE_W-1:0] den1_reg;
    logic [CHARGE_W-1:0] excess;

    assign excess = q_reg - CHARGE_W'(qt_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg <= N1W'(trise_reg) * N1W'(qt_reg);
            num2_reg <= N2W'(excess) * N2W'(PS_PER_NS);
            den1_reg <= q_reg;
        end
    end

    // first chains: crossing delay and discharge time in ps
    logic [QUO_W-1:0] quo1;
    logic [QUO_W-1:0] quo2;

    tcd_div_chain #(.DW (CHARGE_W), .QW (QUO_W)) u_div_rise (
        .clk (clk),
        .en  (en),
        .num ((QUO_W+CHARGE_W)'(num1_reg)),
        .den (den1_reg),
        .quo (quo1)
    );

    tcd_div_chain #(.DW (CURRENT_W), .QW (QUO_W)) u_div_fall (
        .clk (clk),
        .en  (en),
        .num ((QUO_W+CURRENT_W)'(num2_reg)),
        .den (cur_reg),
        .quo (quo2)
    );

    // times in ps
    logic [T1W-1:0] t1_reg;
    logic [T2W-1:0] t2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= T1W'(quo1[TRISE_W-1:0]) + T1W'(offset_reg);
            t2_reg <= quo2 + T2W'(offset_reg) + T2W'(trise_reg);
        end
    end

    // second chains: tick conversion
    logic [QUO_W-1:0] tk1;
    logic [QUO_W-1:0] tk2;

    tcd_div_chain #(.DW (PERIOD_W), .QW (QUO_W)) u_div_start (
        .clk (clk),
        .en  (en),
        .num ((QUO_W+PERIOD_W)'(t1_reg)),
        .den (period_reg),
        .quo (tk1)
    );

    tcd_div_chain #(.DW (PERIOD_W), .QW (QUO_W)) u_div_stop (
        .clk (clk),
        .en  (en),
        .num ((QUO_W+PERIOD_W)'(t2_reg)),
        .den (period_reg),
        .quo (tk2)
    );

    // output stage: floor + 1 with saturation
    logic [TICK_W-1:0] start_next;
    logic [TICK_W-1:0] stop_next;
    logic [TICK_W-1:0] start_reg;
    logic [TICK_W-1:0] stop_reg;
    logic [TICK_W-1:0] tot_reg;

    always_comb
    begin
        start_next = (tk1 >= QUO_W'(TICK_MAX)) ? TICK_MAX : tk1[TICK_W-1:0] + TICK_W'(1);
        stop_next  = (tk2 >= QUO_W'(TICK_MAX)) ? TICK_MAX : tk2[TICK_W-1:0] + TICK_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            start_reg <= start_next;
            stop_reg  <= stop_next;
            tot_reg   <= (stop_next >= start_next) ? stop_next - start_next : '0;
        end
    end

    assign out_valid       = valid_reg[NSTG-1];
    assign start_tick      = start_reg;
    assign stop_tick       = stop_reg;
    assign tot_ticks       = tot_reg;
    assign below_threshold = below_reg[NSTG-1];

    `TCD_ASSERT_NOW(a_below_zero_tot, out_valid && below_threshold, tot_ticks == '0)
    `TCD_ASSERT_NOW(a_stop_after_start, out_valid, stop_tick >= start_tick)
    `TCD_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, valid_reg[0])
    `TCD_ASSERT_NOW(a_divisors_nonzero, 1'b1, cur_reg != '0 && period_reg != '0)

endmodule

@@ rtl/tcd_div_cell.sv @@
// ----------------------------------------------------------------------------
// tcd_div_cell
// One restoring-division step: a single quotient bit per cell, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcd_div_cell #(
    parameter int DW = 16,
    parameter int QW = 35
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] lq_in,
    input  logic [DW-1:0] den_in,
    output logic [DW-1:0] rem_out,
    output logic [QW-1:0] lq_out,
    output logic [DW-1:0] den_out
);

    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] lq_reg, lq_next;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // dividend bits leave at the top of lq, quotient bits enter at the bottom
    always_comb
    begin
        trial    = {rem_in, lq_in[QW-1]};
        diff     = trial - {1'b0, den_in};
        ge       = (trial >= {1'b0, den_in});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        lq_next  = {lq_in[QW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            lq_reg  <= lq_next;
            den_reg <= den_in;
        end
    end

    assign rem_out = rem_reg;
    assign lq_out  = lq_reg;
    assign den_out = den_reg;

endmodule

@@ rtl/tcd_div_chain.sv @@
// ----------------------------------------------------------------------------
// tcd_div_chain
// Row of division cells; one dividend enters and one quotient leaves per clock while en is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcd_div_chain #(
    parameter int DW = 16,
    parameter int QW = 35
) (
    input  logic             clk,
    input  logic             en,
    input  logic [QW+DW-1:0] num,   // top DW bits must be below den
    input  logic [DW-1:0]    den,
    output logic [QW-1:0]    quo
);

    logic [DW-1:0] rem_w [QW+1];
    logic [QW-1:0] lq_w  [QW+1];
    logic [DW-1:0] den_w [QW+1];

    assign rem_w[0] = num[QW+DW-1:QW];
    assign lq_w[0]  = num[QW-1:0];
    assign den_w[0] = den;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        tcd_div_cell #(
            .DW (DW),
            .QW (QW)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (rem_w[i]),
            .lq_in   (lq_w[i]),
            .den_in  (den_w[i]),
            .rem_out (rem_w[i+1]),
            .lq_out  (lq_w[i+1]),
            .den_out (den_w[i+1])
        );
    end

    assign quo = lq_w[QW];

endmodule

@@ tb/sv/tcd_checker.sv @@
// ----------------------------------------------------------------------------
// tcd_checker
// Watches both channels of the TOT digitizer, predicts each result from the
// charge and the register settings, and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcd_checker
    import tcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [CHARGE_W-1:0]   charge_e,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [TICK_W-1:0]     tot_ticks,
    input  logic [TICK_W-1:0]     start_tick,
    input  logic [TICK_W-1:0]     stop_tick,
    input  logic                  below_threshold,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [TICK_W-1:0] tot;
        logic [TICK_W-1:0] start;
        logic [TICK_W-1:0] stop;
        logic              below;
    } tot_hit_t;

    logic [THRESH_W-1:0]  thr;
    logic [CURRENT_W-1:0] cur;
    logic [CTIME_W-1:0]   ctime;
    logic [PERIOD_W-1:0]  period;
    logic [OFFSET_W-1:0]  offset;

    tot_hit_t expected_hits[$];

    function automatic logic [TICK_W-1:0] ps_to_tick(longint unsigned t_ps,
                                                     longint unsigned per);
        longint unsigned q;
        q = t_ps / per;
        if (q >= 64'hFFFFFF)
            return TICK_MAX;
        return TICK_W'(q + 64'd1);
    endfunction

    function automatic tot_hit_t digitize(logic [CHARGE_W-1:0] charge);
        longint unsigned q, qt, c, per, tr, t1, t2;
        tot_hit_t h;
        q   = 64'(charge);
        qt  = 64'(thr);
        c   = (cur == '0) ? 64'd60 : 64'(cur);
        per = (period == '0) ? 64'd1 : 64'(period);
        tr  = 64'(ctime) * 64'd1000;
        h.below = 1'b0;
        if (q <= qt)
        begin
            h.below = 1'b1;
            q = 64'd1;
            qt = 64'd1;
        end
        t1 = (tr * qt) / q + 64'(offset);
        t2 = ((q - qt) * 64'd1000) / c + 64'(offset) + tr;
        h.start = ps_to_tick(t1, per);
        h.stop  = ps_to_tick(t2, per);
        h.tot   = (h.stop >= h.start) ? h.stop - h.start : '0;
        return h;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        tot_hit_t got, exp_hit;
        if (!rst_n)
        begin
            thr <= 20'd3000;
            cur <= 12'd60;
            ctime <= 12'd100;
            period <= 16'd6410;
            offset <= 16'd0;
            fail_count <= 0;
            expected_hits.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_idx_t'(cfg_index))
                    IDX_THRESHOLD: thr    <= cfg_data[THRESH_W-1:0];
                    IDX_CURRENT:   cur    <= cfg_data[CURRENT_W-1:0];
                    IDX_CTIME:     ctime  <= cfg_data[CTIME_W-1:0];
                    IDX_PERIOD:    period <= cfg_data[PERIOD_W-1:0];
                    IDX_OFFSET:    offset <= cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_hits.push_back(digitize(charge_e));
            if (out_valid && out_ready)
            begin
                got = '{tot_ticks, start_tick, stop_tick, below_threshold};
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_hit = expected_hits.pop_front();
                    if (got !== exp_hit)
                    begin
                        $display("%0t: expected tot %0d start %0d stop %0d below %0d",
                                 $time, exp_hit.tot, exp_hit.start, exp_hit.stop,
                                 exp_hit.below);
                        $display("%0t: actual   tot %0d start %0d stop %0d below %0d",
                                 $time, got.tot, got.start, got.stop, got.below);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending = expected_hits.size();

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the TOT digitizer: directed charges and register
// extremes, then random charges over several register settings and idling
// phases on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import tcd_pkg::*;
();

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [CHARGE_W-1:0]   charge_e;
    logic                  out_valid;
    logic                  out_ready;
    logic [TICK_W-1:0]     tot_ticks;
    logic [TICK_W-1:0]     start_tick;
    logic [TICK_W-1:0]     stop_tick;
    logic                  below_threshold;
    int                    fail_count;
    int                    pending;
    int                    src_idle_pct;
    int                    sink_stall_pct;
    logic [THRESH_W-1:0]   cur_thr;

    tot_charge_digitizer_core uut (.*);
    tcd_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver stall
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == IDX_THRESHOLD)
            cur_thr = val[THRESH_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // valid stays up between back-to-back transactions; it only drops while idling or draining
    task automatic send_charge(logic [CHARGE_W-1:0] q);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        charge_e <= q;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    function automatic logic [CHARGE_W-1:0] rand_charge();
        case ($urandom_range(5))
            0: return CHARGE_W'($urandom_range(32'(cur_thr)));
            1: return CHARGE_W'(cur_thr) + CHARGE_W'($urandom_range(64));
            2: return CHARGE_W'($urandom);
            default: return CHARGE_W'(cur_thr) +
                            (CHARGE_W'($urandom) & (24'hFFFFFF >> $urandom_range(23)));
        endcase
    endfunction

    task automatic random_block(int n);
        for (int i = 0; i < n; i++)
        begin
            case ((i * 4) / n)
                0:
                begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 46; sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;  sink_stall_pct = 46;
                end
                default:
                begin
                    src_idle_pct = 24; sink_stall_pct = 24;
                end
            endcase
            send_charge(rand_charge());
        end
        src_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        charge_e = '0;
        out_ready = 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        cur_thr = 20'd3000;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, zero, at/around threshold, full scale
        send_charge(24'd0);
        send_charge(24'd1);
        send_charge(24'd3000);
        send_charge(24'd3001);
        send_charge(24'd20000);
        send_charge(24'hFFFFFF);
        send_charge(24'hAAAAAA);
        send_charge(24'h555555);
        drain();
        // zero current and zero period, max charge time and offset, zero threshold
        cfg_write(IDX_CURRENT, 20'd0);
        cfg_write(IDX_PERIOD, 20'd0);
        cfg_write(IDX_CTIME, 20'hFFF);
        cfg_write(IDX_OFFSET, 20'hFFFF);
        cfg_write(IDX_THRESHOLD, 20'd0);
        send_charge(24'd0);
        send_charge(24'd1);
        send_charge(24'hFFFFFF);
        send_charge(24'd12345);
        drain();
        cfg_write(IDX_CURRENT, 20'hFFF);
        cfg_write(IDX_PERIOD, 20'hFFFF);
        cfg_write(IDX_THRESHOLD, 20'hFFFFF);
        cfg_write(IDX_CTIME, 20'd0);
        cfg_write(IDX_OFFSET, 20'd0);
        send_charge(24'hFFFFF);
        send_charge(24'h100000);
        send_charge(24'hFFFFFF);
        drain();
        cfg_write(IDX_CURRENT, 20'd1);
        cfg_write(IDX_PERIOD, 20'd1);
        cfg_write(IDX_THRESHOLD, 20'd1);
        send_charge(24'd2);
        send_charge(24'hFFFFFF);
        drain();

        // random settings
        for (int s = 0; s < 5; s++)
        begin
            if (s == 0)
                cfg_write(IDX_THRESHOLD, 20'd3000);
            else
                cfg_write(IDX_THRESHOLD, CFG_DATA_W'($urandom) >> $urandom_range(19));
            cfg_write(IDX_CURRENT, CFG_DATA_W'($urandom & 32'hFFF));
            cfg_write(IDX_CTIME, CFG_DATA_W'($urandom & 32'hFFF));
            cfg_write(IDX_PERIOD, (s == 4) ? 20'hFFFF :
                      CFG_DATA_W'($urandom_range(65535, 1)));
            cfg_write(IDX_OFFSET, CFG_DATA_W'($urandom & 32'hFFFF));
            random_block(200);
            drain();
        end

        if (fail_count == 0)
            $display("tot_charge_digitizer_core: match");
        else
            $display("tot_charge_digitizer_core: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tot_charge_digitizer_core: mismatch");
        $finish;
    end

endmodule
